[rtl/mapd_pkg.sv]
// ----------------------------------------------------------------------------
// mapd_pkg
// Shared constants, register map and duty table of the moving average to
// PWM duty block.
// ----------------------------------------------------------------------------
package mapd_pkg;

   localparam int SAMPLE_W     = 8;
   localparam int AVG_W        = 8;
   localparam int PWM_W        = 11;
   localparam int OFFSET_W     = 5;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 24;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [OFFSET_W-1:0] OFFSET_CEIL = 5'd26;

   localparam logic REG_ZERO_THRESHOLD = 1'b0;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [AVG_W-1:0]    avg_type;
   typedef logic [PWM_W-1:0]    pwm_type;
   typedef logic [OFFSET_W-1:0] offset_type;

   // offset * 2000 / 26, truncated
   function automatic pwm_type pwm_lut(input offset_type offset);
      pwm_type r;
      r = '0;
      unique case (offset)
         5'd0:    r = 11'd0;
         5'd1:    r = 11'd76;
         5'd2:    r = 11'd153;
         5'd3:    r = 11'd230;
         5'd4:    r = 11'd307;
         5'd5:    r = 11'd384;
         5'd6:    r = 11'd461;
         5'd7:    r = 11'd538;
         5'd8:    r = 11'd615;
         5'd9:    r = 11'd692;
         5'd10:   r = 11'd769;
         5'd11:   r = 11'd846;
         5'd12:   r = 11'd923;
         5'd13:   r = 11'd1000;
         5'd14:   r = 11'd1076;
         5'd15:   r = 11'd1153;
         5'd16:   r = 11'd1230;
         5'd17:   r = 11'd1307;
         5'd18:   r = 11'd1384;
         5'd19:   r = 11'd1461;
         5'd20:   r = 11'd1538;
         5'd21:   r = 11'd1615;
         5'd22:   r = 11'd1692;
         5'd23:   r = 11'd1769;
         5'd24:   r = 11'd1846;
         5'd25:   r = 11'd1923;
         default: r = 11'd2000;
      endcase
      return r;
   endfunction

endpackage

[rtl/mapd_cell.sv]
// ----------------------------------------------------------------------------
// mapd_cell
// One window slot: holds a sample and hands it to the next slot on shift.
// ----------------------------------------------------------------------------
module mapd_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  mapd_pkg::sample_type d_in,
   output mapd_pkg::sample_type q_out
);
   import mapd_pkg::*;

   sample_type sample_ff;
   sample_type sample_in;

   assign sample_in = shift ? d_in : sample_ff;

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign q_out = sample_ff;

endmodule

[rtl/mapd_window.sv]
// ----------------------------------------------------------------------------
// mapd_window
// Sliding window as a chain of slots with a fill count and running sum.
// ----------------------------------------------------------------------------
module mapd_window #(
   parameter int WINDOW_SLOTS = 16,
   parameter int SUM_W        = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mapd_pkg::sample_type sample,
   input  logic                 take,
   output logic                 item_valid,
   output logic [SUM_W-1:0]     window_sum
);
   import mapd_pkg::*;

   localparam int CELLS = WINDOW_SLOTS - 1;
   localparam int CNT_W = (WINDOW_SLOTS > 2) ? $clog2(WINDOW_SLOTS) : 1;

   sample_type             chain [CELLS+1];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   valid_ff, valid_in;
   logic                   full;
   logic [SUM_W-1:0]       drop;

   assign chain[0] = sample;

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      mapd_cell u_cell (
         .clock (clock),
         .shift (push),
         .d_in  (chain[g]),
         .q_out (chain[g+1])
      );
   end

   assign full = (count_ff == CNT_W'(CELLS));
   assign drop = full ? SUM_W'(chain[CELLS]) : '0;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (push) begin
         sum_in = sum_ff + SUM_W'(sample) - drop;
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      priority if (push) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   assign item_valid = valid_ff;
   assign window_sum = sum_ff;

endmodule

[rtl/mapd_scale.sv]
// ----------------------------------------------------------------------------
// mapd_scale
// Divide the window sum by the slot count, offset, clamp and map to duty.
// ----------------------------------------------------------------------------
module mapd_scale #(
   parameter int WINDOW_SLOTS = 16,
   parameter int SUM_W        = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [SUM_W-1:0]     in_sum,
   output logic                 in_ready,
   input  mapd_pkg::avg_type    zero_threshold,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mapd_pkg::avg_type    out_average,
   output mapd_pkg::pwm_type    out_pwm
);
   import mapd_pkg::*;

   localparam int SHIFT  = SUM_W + $clog2(WINDOW_SLOTS);
   localparam int MULT_W = SUM_W + 2;
   localparam int PROD_W = SUM_W + MULT_W;
   localparam longint unsigned MULT =
      ((64'd1 << SHIFT) + longint'(WINDOW_SLOTS) - 64'd1) / longint'(WINDOW_SLOTS);
   localparam logic [MULT_W-1:0] MULT_K = MULT_W'(MULT);

   logic              v2_ff, v2_in, v3_ff, v3_in;
   logic              ready2, ready3;
   logic [PROD_W-1:0] prod;
   avg_type           avg2_ff, avg2_in;
   avg_type           avg3_ff, avg3_in;
   pwm_type           pwm3_ff, pwm3_in;
   offset_type        offset;
   avg_type           diff;

   assign ready3 = !v3_ff || out_ready;
   assign ready2 = !v2_ff || ready3;

   assign prod    = PROD_W'(in_sum) * PROD_W'(MULT_K);
   assign avg2_in = ready2 ? prod[SHIFT +: AVG_W] : avg2_ff;
   assign v2_in   = ready2 ? in_valid : v2_ff;

   always_comb begin
      diff   = avg2_ff - zero_threshold;
      offset = '0;
      if (avg2_ff > zero_threshold) begin
         offset = (diff > AVG_W'(OFFSET_CEIL)) ? OFFSET_CEIL : diff[OFFSET_W-1:0];
      end
   end

   assign avg3_in = ready3 ? avg2_ff : avg3_ff;
   assign pwm3_in = ready3 ? pwm_lut(offset) : pwm3_ff;
   assign v3_in   = ready3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      avg2_ff <= avg2_in;
      avg3_ff <= avg3_in;
      pwm3_ff <= pwm3_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign in_ready    = ready2;
   assign out_valid   = v3_ff;
   assign out_average = avg3_ff;
   assign out_pwm     = pwm3_ff;

endmodule

[rtl/moving_average_to_pwm_duty_core.sv]
// ----------------------------------------------------------------------------
// moving_average_to_pwm_duty_core
// Sliding window average of samples, offset by a threshold, mapped to PWM duty.
// Throughput: one item per cycle while the response side does not stall; the
//   running sum and the slot chain update in the accept cycle, divide and duty
//   lookup follow in two registered stages.
// Reset clears the fill count, running sum, pipeline valids and threshold.
// ----------------------------------------------------------------------------
module moving_average_to_pwm_duty_core #(
   parameter int WINDOW_SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mapd_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mapd_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [7:0] window_average,
                                                            // [18:8] pwm_compare
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mapd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mapd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mapd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import mapd_pkg::*;

   localparam int SUM_W = $clog2((WINDOW_SLOTS - 1) * 255 + 1);

   logic             win_valid, scale_ready, push, take;
   logic [SUM_W-1:0] win_sum;
   avg_type          thr_ff, thr_in;
   avg_type          rsp_avg;
   pwm_type          rsp_pwm;
   logic             csr_write, csr_hit;

   assign req_tready = !win_valid || scale_ready;
   assign push       = req_tvalid && req_tready;
   assign take       = win_valid && scale_ready;

   mapd_window #(
      .WINDOW_SLOTS (WINDOW_SLOTS),
      .SUM_W        (SUM_W)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .sample     (req_tdata[SAMPLE_W-1:0]),
      .take       (take),
      .item_valid (win_valid),
      .window_sum (win_sum)
   );

   mapd_scale #(
      .WINDOW_SLOTS (WINDOW_SLOTS),
      .SUM_W        (SUM_W)
   ) u_scale (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (win_valid),
      .in_sum         (win_sum),
      .in_ready       (scale_ready),
      .zero_threshold (thr_ff),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_average    (rsp_avg),
      .out_pwm        (rsp_pwm)
   );

   assign rsp_tdata = {(RSP_DATA_W - PWM_W - AVG_W)'(0), rsp_pwm, rsp_avg};

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == REG_ZERO_THRESHOLD);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign thr_in     = (csr_write && csr_hit) ? csr_pwdata[AVG_W-1:0] : thr_ff;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else begin
         thr_ff <= thr_in;
      end
   end

   a_pwm_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_pwm <= 11'd2000))
      else $error("pwm compare above period");

   a_below_thr : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_avg <= thr_ff)) |-> (rsp_pwm == '0))
      else $error("nonzero duty with average at or below threshold");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while output side is free");

endmodule

[sim/mapd_duty_checker.sv]
// ----------------------------------------------------------------------------
// mapd_duty_checker
// Watches the sample, duty and register ports of the moving average to PWM
// duty core. Keeps its own window of samples, running sum and threshold,
// predicts the average and compare value for every accepted sample, and
// checks each accepted result and each threshold register read against it.
// ----------------------------------------------------------------------------
module mapd_duty_checker #(
   parameter int WINDOW_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [mapd_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] sample
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [mapd_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [7:0] window_average,
                                                        // [18:8] pwm_compare
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mapd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mapd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [mapd_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                            csr_pready,
   output int                              failures,
   output int                              outstanding
);
   import mapd_pkg::*;

   localparam int SLOT_W      = $clog2(WINDOW_SLOTS);
   localparam int SUM_W       = $clog2(WINDOW_SLOTS * 255 + 1);
   localparam int DUTY_PERIOD = 2000;
   localparam int PAD_LSB     = AVG_W + PWM_W;

   typedef struct packed {
      avg_type average;
      pwm_type compare;
   } duty_result_type;

   sample_type        window_ring [WINDOW_SLOTS];
   logic [SLOT_W-1:0] write_slot;
   logic [SLOT_W-1:0] read_slot;
   logic [SUM_W-1:0]  window_sum;
   avg_type           zero_threshold;
   duty_result_type   expected_duty [$];
   int                mismatch_total;

   function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
      return SLOT_W'((int'(s) + 1) % WINDOW_SLOTS);
   endfunction

   function automatic duty_result_type advance_window(input sample_type s);
      duty_result_type r;
      int              offset;
      if (ring_next(write_slot) == read_slot) begin
         window_sum -= SUM_W'(window_ring[read_slot]);
         read_slot = ring_next(read_slot);
      end
      window_ring[write_slot] = s;
      window_sum += SUM_W'(s);
      write_slot = ring_next(write_slot);
      r.average = avg_type'(int'(window_sum) / WINDOW_SLOTS);
      if (r.average <= zero_threshold)
         offset = 0;
      else
         offset = int'(r.average) - int'(zero_threshold);
      if (offset > int'(OFFSET_CEIL))
         offset = int'(OFFSET_CEIL);
      r.compare = pwm_type'(offset * DUTY_PERIOD / int'(OFFSET_CEIL));
      return r;
   endfunction

   always @(posedge clock) begin : watch
      duty_result_type got;
      duty_result_type want;
      logic            reg_hit;
      reg_hit = (csr_paddr[CSR_ADDR_W-1:2] == REG_ZERO_THRESHOLD) && (csr_paddr[1:0] == 2'b00);
      if (reset) begin
         write_slot = '0;
         read_slot = '0;
         window_sum = '0;
         zero_threshold = '0;
         expected_duty.delete();
         mismatch_total = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.average = rsp_tdata[AVG_W-1:0];
            got.compare = rsp_tdata[AVG_W +: PWM_W];
            if (rsp_tdata[RSP_DATA_W-1:PAD_LSB] != '0) begin
               $error("padding expected 0 actual %0h", rsp_tdata[RSP_DATA_W-1:PAD_LSB]);
               mismatch_total++;
            end
            if (expected_duty.size() == 0) begin
               $error("unexpected item: window_average %0d pwm_compare %0d",
                      got.average, got.compare);
               mismatch_total++;
            end else begin
               want = expected_duty.pop_front();
               if (got.average != want.average) begin
                  $error("window_average expected %0d actual %0d", want.average, got.average);
                  mismatch_total++;
               end
               if (got.compare != want.compare) begin
                  $error("pwm_compare expected %0d actual %0d", want.compare, got.compare);
                  mismatch_total++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_duty.push_back(advance_window(req_tdata[SAMPLE_W-1:0]));
         if (csr_psel && csr_penable && csr_pready && reg_hit) begin
            if (csr_pwrite) begin
               zero_threshold = csr_pwdata[AVG_W-1:0];
            end else if (csr_prdata != CSR_DATA_W'(zero_threshold)) begin
               $error("zero_threshold expected %0d actual %0d", zero_threshold, csr_prdata);
               mismatch_total++;
            end
         end
      end
      failures <= mismatch_total;
      outstanding <= expected_duty.size();
   end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives samples and threshold writes into the moving average to PWM duty
// core with random gaps on both channels, runs a directed window fill and
// drain, then phases of random and level-tracking samples at several
// thresholds, and reports the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module testbench;
   import mapd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = CSR_ADDR_W'(REG_ZERO_THRESHOLD) << 2;
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR  = THRESHOLD_ADDR + CSR_ADDR_W'(4);
   localparam logic                  CSR_READ       = 1'b0;
   localparam logic                  CSR_WRITE      = 1'b1;
   localparam int                    PHASES         = 12;
   localparam int                    PHASE_ITEMS    = 120;
   localparam int                    SETTLE_CYCLES  = 8;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  steady      = 1'b0;
   int                    failures;
   int                    outstanding;

   always #5 clock = ~clock;

   moving_average_to_pwm_duty_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mapd_duty_checker duty_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .outstanding (outstanding)
   );

   function automatic int draw_gap();
      return steady ? 0 : int'($urandom_range(0, 9));
   endfunction

   function automatic sample_type level_sample(input int level, input int spread);
      int v;
      v = level + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      return sample_type'(v);
   endfunction

   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input sample_type s);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(s);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_duty();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : duty_sink
      int stall;
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      int thr;
      int level;
      int mode;
      sample_type s;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(CSR_READ, THRESHOLD_ADDR, '0);

      // fill the window, hold it full, then drain it toward zero
      send_sample(8'd0);
      repeat (16) send_sample(8'd255);
      repeat (8) send_sample(8'd0);
      drain_duty();
      csr_access(CSR_WRITE, UNMAPPED_ADDR, CSR_DATA_W'(8'hA5));
      csr_access(CSR_READ, THRESHOLD_ADDR, '0);

      for (int p = 0; p < PHASES; p++) begin
         drain_duty();
         steady = ((p % 4) == 3);
         case (p)
            0:       thr = 255;
            1:       thr = 0;
            2:       thr = 1;
            3:       thr = 254;
            default: thr = int'($urandom_range(0, 239));
         endcase
         csr_access(CSR_WRITE, THRESHOLD_ADDR, CSR_DATA_W'(thr));
         csr_access(CSR_READ, THRESHOLD_ADDR, '0);
         mode = p % 3;
         level = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ((i % 24) == 0) begin
               level = (thr + int'($urandom_range(0, 32))) * 16 / 15;
               if (level > 255)
                  level = 255;
            end
            case (mode)
               0:       s = sample_type'($urandom_range(0, 255));
               1:       s = level_sample(level, 12);
               default: begin
                  if ($urandom_range(0, 9) == 0)
                     s = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                  else
                     s = level_sample(level, 40);
               end
            endcase
            send_sample(s);
         end
      end

      drain_duty();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("** moving_average_to_pwm_duty_core: PASSED **");
      else
         $display("** moving_average_to_pwm_duty_core: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("** moving_average_to_pwm_duty_core: FAILED **");
      $finish;
   end

endmodule
